/* hdl/ppm_pkg.sv */
// ============================================================================
// ppm_pkg: shared types and constants of the particle pair merge core
// Slot sizes, field widths and the command and status structs that join the
// controller to the datapath.
// ============================================================================
package ppm_pkg;

    localparam int MAX_PARTICLES = 32;
    localparam int SLOT_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int ID_W          = 24;
    localparam int COORD_W       = 32;
    localparam int MASS_W        = 32;
    localparam int MRG_W         = 16;
    localparam int DIST_W        = 63;
    localparam int PROD_W        = 64;
    localparam int DIV_N_W       = 64;
    localparam int DIV_D_W       = 33;
    localparam int NUM_AXES      = 6;
    localparam int AXIS_W        = 3;

    // Controller to datapath.
    typedef struct packed {
        logic              load;
        logic              rd;         // read slots r_i and r_j into operand regs
        logic [SLOT_W-1:0] idx_i;
        logic [SLOT_W-1:0] idx_j;
        logic              dist_go;    // compare squared operand distance with limit
        logic              mean_go;    // start weighted mean for one axis
        logic [AXIS_W-1:0] axis;
        logic              mean_save;  // store quotient of axis
        logic              commit;     // write merged slot back
        logic              emit_rd;    // read slot idx_i for output
        logic              emit;       // drive output strobe
        logic              emit_last;
        logic              clear;      // drop all alive bits
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic both_alive;
        logic near;
        logic tot_zero;
        logic div_done;
    } t_sts;

endpackage

/* hdl/particle_pair_merge_core.sv */
// ============================================================================
// particle_pair_merge_core: pairwise particle merge with momentum conservation
// Loads up to MAX_PARTICLES slots, merges close pairs, then emits every loaded slot.
// ============================================================================
// Loading takes one word per cycle while busy is low.
// After the last word, busy rises; each pair is checked through ST_RD, ST_SQ,
// ST_CMP and ST_CHK, and a merge of nonzero total mass runs six weighted-mean
// divisions on the shared bit-serial divider. Results follow one word per slot, no stall.
// Reset (synchronous, active low) empties all slots and clears r_dist.
module particle_pair_merge_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [ppm_pkg::DIST_W-1:0]     i_cfg_wdata,
    input  logic                           i_valid_req,
    input  logic [ppm_pkg::ID_W-1:0]       i_particle_id,
    input  logic signed [31:0]             i_pos_x,
    input  logic signed [31:0]             i_pos_y,
    input  logic signed [31:0]             i_pos_z,
    input  logic signed [31:0]             i_vel_x,
    input  logic signed [31:0]             i_vel_y,
    input  logic signed [31:0]             i_vel_z,
    input  logic [ppm_pkg::MASS_W-1:0]     i_mass,
    input  logic [ppm_pkg::MRG_W-1:0]      i_merge_count,
    input  logic                           i_last_in,
    output logic                           o_strobe,
    output logic                           o_alive,
    output logic [ppm_pkg::ID_W-1:0]       o_out_id,
    output logic signed [31:0]             o_out_pos_x,
    output logic signed [31:0]             o_out_pos_y,
    output logic signed [31:0]             o_out_pos_z,
    output logic signed [31:0]             o_out_vel_x,
    output logic signed [31:0]             o_out_vel_y,
    output logic signed [31:0]             o_out_vel_z,
    output logic [ppm_pkg::MASS_W-1:0]     o_out_mass,
    output logic [ppm_pkg::MRG_W-1:0]      o_out_merges,
    output logic                           o_last_out
);
    logic [ppm_pkg::DIST_W-1:0]   r_dist;
    ppm_pkg::t_cmd                cmd;
    ppm_pkg::t_sts                sts;
    logic [ppm_pkg::SLOT_W-1:0]   wr_idx;
    logic [6*32-1:0]              kin_in, kin_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_dist <= '0;
        else if (i_cfg_we) r_dist <= i_cfg_wdata;
    end

    assign kin_in = {i_vel_z, i_vel_y, i_vel_x, i_pos_z, i_pos_y, i_pos_x};

    ppm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start & ~busy),
        .i_last_in(i_last_in),
        .o_busy   (busy),
        .o_wr_idx (wr_idx),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    ppm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_dist       (r_dist),
        .i_wr_idx     (wr_idx),
        .i_valid_req  (i_valid_req),
        .i_particle_id(i_particle_id),
        .i_kin        (kin_in),
        .i_mass       (i_mass),
        .i_merge_count(i_merge_count),
        .o_strobe     (o_strobe),
        .o_alive      (o_alive),
        .o_out_id     (o_out_id),
        .o_kin        (kin_out),
        .o_out_mass   (o_out_mass),
        .o_out_merges (o_out_merges),
        .o_last_out   (o_last_out)
    );

    assign o_out_pos_x = kin_out[31:0];
    assign o_out_pos_y = kin_out[63:32];
    assign o_out_pos_z = kin_out[95:64];
    assign o_out_vel_x = kin_out[127:96];
    assign o_out_vel_y = kin_out[159:128];
    assign o_out_vel_z = kin_out[191:160];
endmodule

/* hdl/ppm_divider.sv */
// ============================================================================
// ppm_divider: restoring divider with round-to-nearest
// One quotient bit per cycle over a 64-bit dividend and a 33-bit divisor.
// ============================================================================
module ppm_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  logic [ppm_pkg::DIV_N_W-1:0]     i_num,
    input  logic [ppm_pkg::DIV_D_W-1:0]     i_den,
    output logic                            o_done,
    output logic [ppm_pkg::DIV_N_W:0]       o_quot
);
    localparam int NW = ppm_pkg::DIV_N_W;
    localparam int DW = ppm_pkg::DIV_D_W;

    logic [NW-1:0]        r_q;
    logic [DW:0]          r_rem;
    logic [DW-1:0]        r_den;
    logic [6:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [NW:0]          r_quot;
    logic [DW:0]          n_rem_sh;
    logic [DW:0]          n_rem_sub;
    logic                 n_bit;
    logic [DW+1:0]        n_twice;

    always_comb begin
        n_rem_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        n_bit     = n_rem_sh >= {1'b0, r_den};
        n_rem_sub = n_bit ? n_rem_sh - {1'b0, r_den} : n_rem_sh;
    end

    // Round up when 2r >= d, which equals r >= d - r.
    assign n_twice = {n_rem_sub, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 7'(NW);
            end else if (r_busy) begin
                r_q   <= {r_q[NW-2:0], n_bit};
                r_rem <= n_rem_sub;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= {1'b0, r_q[NW-2:0], n_bit} +
                              (NW+1)'(n_twice >= {2'b0, r_den});
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* hdl/ppm_datapath.sv */
// ============================================================================
// ppm_datapath: slot storage and merge arithmetic
// Holds the slots, computes squared distance and weighted means, and drives
// the result ports.
// ============================================================================
module ppm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppm_pkg::t_cmd                     i_cmd,
    output ppm_pkg::t_sts                     o_sts,
    input  logic [ppm_pkg::DIST_W-1:0]        i_dist,
    input  logic [ppm_pkg::SLOT_W-1:0]        i_wr_idx,
    input  logic                              i_valid_req,
    input  logic [ppm_pkg::ID_W-1:0]          i_particle_id,
    input  logic [6*ppm_pkg::COORD_W-1:0]     i_kin,
    input  logic [ppm_pkg::MASS_W-1:0]        i_mass,
    input  logic [ppm_pkg::MRG_W-1:0]         i_merge_count,
    output logic                              o_strobe,
    output logic                              o_alive,
    output logic [ppm_pkg::ID_W-1:0]          o_out_id,
    output logic [6*ppm_pkg::COORD_W-1:0]     o_kin,
    output logic [ppm_pkg::MASS_W-1:0]        o_out_mass,
    output logic [ppm_pkg::MRG_W-1:0]         o_out_merges,
    output logic                              o_last_out
);
    localparam int N  = ppm_pkg::MAX_PARTICLES;
    localparam int CW = ppm_pkg::COORD_W;
    localparam int MW = ppm_pkg::MASS_W;

    logic [N-1:0]                  r_alive;
    logic [ppm_pkg::ID_W-1:0]      r_id_mem   [N];
    logic [6*CW-1:0]               r_kin_mem  [N];
    logic [MW-1:0]                 r_mass_mem [N];
    logic [ppm_pkg::MRG_W-1:0]     r_mrg_mem  [N];

    logic [6*CW-1:0]               r_ka, r_kb;
    logic [MW-1:0]                 r_ma, r_mb;
    logic [ppm_pkg::MRG_W-1:0]     r_ga, r_gb;
    logic                          r_aa, r_ab;
    logic [6*CW-1:0]               r_newk;
    logic [2:0][63:0]              r_sq;
    logic                          r_near;
    logic [64:0]                   n_dsum;
    logic [2:0][32:0]              n_diff;
    logic [2:0][31:0]              n_dmag;
    logic [ppm_pkg::DIV_N_W-1:0]   r_num;
    logic                          r_neg;
    logic                          r_dgo;
    logic                          div_done;
    logic [ppm_pkg::DIV_N_W:0]     div_q;
    logic [32:0]                   n_tot;
    logic [31:0]                   n_qs;
    logic [63:0]                   n_pa, n_pb;
    logic [CW-1:0]                 n_a, n_b, n_ea, n_eb;
    logic                          n_keep_i;

    assign n_tot    = {1'b0, r_ma} + {1'b0, r_mb};
    assign n_keep_i = r_ma >= r_mb;
    assign n_a      = r_ka[i_cmd.axis*CW +: CW];
    assign n_b      = r_kb[i_cmd.axis*CW +: CW];
    assign n_ea     = n_a[CW-1] ? -n_a : n_a;
    assign n_eb     = n_b[CW-1] ? -n_b : n_b;
    assign n_pa     = n_ea * r_ma;
    assign n_pb     = n_eb * r_mb;

    // Each coordinate difference needs 33 bits; its magnitude fits in 32.
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            n_diff[d] = {r_ka[d*CW+CW-1], r_ka[d*CW +: CW]} -
                        {r_kb[d*CW+CW-1], r_kb[d*CW +: CW]};
            n_dmag[d] = n_diff[d][32] ? 32'(-n_diff[d]) : n_diff[d][31:0];
        end
    end

    always_comb begin
        n_dsum = {1'b0, r_sq[0]} + {1'b0, r_sq[1]} + {1'b0, r_sq[2]};
    end

    // Saturate the magnitude at 2^31, then clamp a positive 2^31.
    always_comb begin
        if (div_q > 65'h80000000) n_qs = 32'h80000000;
        else                      n_qs = div_q[31:0];
        if (r_neg)                n_qs = -n_qs;
        else if (n_qs[31])        n_qs = 32'h7FFFFFFF;
    end

    ppm_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_dgo),
        .i_num  (r_num),
        .i_den  (n_tot),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id_mem[i_wr_idx]   <= i_particle_id;
            r_kin_mem[i_wr_idx]  <= i_kin;
            r_mass_mem[i_wr_idx] <= i_mass;
            r_mrg_mem[i_wr_idx]  <= i_merge_count;
        end
        if (i_cmd.rd || i_cmd.emit_rd) begin
            r_ka <= r_kin_mem[i_cmd.idx_i];
            r_ma <= r_mass_mem[i_cmd.idx_i];
            r_ga <= r_mrg_mem[i_cmd.idx_i];
            r_aa <= r_alive[i_cmd.idx_i];
            o_out_id <= r_alive[i_cmd.idx_i] ? r_id_mem[i_cmd.idx_i] : '0;
        end
        if (i_cmd.rd) begin
            r_kb <= r_kin_mem[i_cmd.idx_j];
            r_mb <= r_mass_mem[i_cmd.idx_j];
            r_gb <= r_mrg_mem[i_cmd.idx_j];
            r_ab <= r_alive[i_cmd.idx_j];
        end
        for (int d = 0; d < 3; d++) begin
            r_sq[d] <= {32'b0, n_dmag[d]} * {32'b0, n_dmag[d]};
        end
        if (i_cmd.dist_go)
            r_near <= (n_dsum[64] ? 64'hFFFFFFFFFFFFFFFF : n_dsum[63:0]) <=
                      {1'b0, i_dist};
        r_dgo <= i_cmd.mean_go;
        if (i_cmd.mean_go) begin
            if (n_a[CW-1] == n_b[CW-1]) begin
                r_num <= n_pa + n_pb; r_neg <= n_a[CW-1];
            end else if (n_pa >= n_pb) begin
                r_num <= n_pa - n_pb; r_neg <= n_a[CW-1];
            end else begin
                r_num <= n_pb - n_pa; r_neg <= n_b[CW-1];
            end
        end
        if (i_cmd.mean_save)
            r_newk[i_cmd.axis*CW +: CW] <= n_qs;
        if (i_cmd.commit) begin
            if (n_keep_i) begin
                if (!o_sts.tot_zero) r_kin_mem[i_cmd.idx_i] <= r_newk;
                r_mass_mem[i_cmd.idx_i] <= n_tot[32] ? '1 : n_tot[31:0];
                r_mrg_mem[i_cmd.idx_i]  <= r_ga + 16'(r_ga != '1);
            end else begin
                if (!o_sts.tot_zero) r_kin_mem[i_cmd.idx_j] <= r_newk;
                r_mass_mem[i_cmd.idx_j] <= n_tot[32] ? '1 : n_tot[31:0];
                r_mrg_mem[i_cmd.idx_j]  <= r_gb + 16'(r_gb != '1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive  <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe   <= i_cmd.emit;
            o_last_out <= i_cmd.emit_last;
            if (i_cmd.load)
                r_alive[i_wr_idx] <= i_valid_req;
            if (i_cmd.commit) begin
                if (n_keep_i) r_alive[i_cmd.idx_j] <= 1'b0;
                else          r_alive[i_cmd.idx_i] <= 1'b0;
            end
            if (i_cmd.clear)
                r_alive <= '0;
        end
    end

    assign o_alive      = o_strobe & r_aa;
    assign o_kin        = r_aa ? r_ka : '0;
    assign o_out_mass   = r_aa ? r_ma : '0;
    assign o_out_merges = r_aa ? r_ga : '0;

    assign o_sts.both_alive = r_aa & r_ab;
    assign o_sts.near       = r_near;
    assign o_sts.tot_zero   = (n_tot == '0);
    assign o_sts.div_done   = div_done;
endmodule

/* hdl/ppm_ctrl.sv */
// ============================================================================
// ppm_ctrl: merge sequencer
// Counts loaded slots, walks every pair in order and then emits each slot.
// ============================================================================
module ppm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_last_in,
    output logic                          o_busy,
    output logic [ppm_pkg::SLOT_W-1:0]    o_wr_idx,
    output ppm_pkg::t_cmd                 o_cmd,
    input  ppm_pkg::t_sts                 i_sts
);
    localparam int SW = ppm_pkg::SLOT_W;
    localparam int CW = ppm_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_LOAD, ST_PAIR, ST_RD, ST_SQ, ST_CMP, ST_CHK,
        ST_MGO, ST_MWAIT, ST_COMMIT, ST_NEXT, ST_EMIT, ST_EMIT2
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [SW-1:0]   r_i, r_j;
    logic [2:0]      r_axis;
    logic            r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_axis  <= '0;
        end else begin
            case (r_state)
                ST_LOAD: if (i_start) begin
                    if (r_cnt != CW'(ppm_pkg::MAX_PARTICLES)) r_cnt <= r_cnt + 1'b1;
                    if (i_last_in) begin
                        r_busy  <= 1'b1;
                        r_i     <= '0;
                        r_j     <= SW'(1);
                        r_state <= ST_PAIR;
                    end
                end
                ST_PAIR: begin
                    // Done with pairs once i+1 reaches the loaded count.
                    if ({1'b0, r_i} + CW'(1) >= r_cnt) begin
                        r_i <= '0;
                        r_state <= ST_EMIT;
                    end else r_state <= ST_RD;
                end
                ST_RD:    r_state <= ST_SQ;
                ST_SQ:    r_state <= ST_CMP;
                ST_CMP:   r_state <= ST_CHK;
                ST_CHK: begin
                    r_axis <= '0;
                    if (i_sts.both_alive && i_sts.near) r_state <= ST_MGO;
                    else                                r_state <= ST_NEXT;
                end
                ST_MGO: r_state <= i_sts.tot_zero ? ST_COMMIT : ST_MWAIT;
                ST_MWAIT: if (i_sts.div_done) begin
                    if (r_axis == 3'(ppm_pkg::NUM_AXES - 1)) r_state <= ST_COMMIT;
                    else begin
                        r_axis  <= r_axis + 3'd1;
                        r_state <= ST_MGO;
                    end
                end
                ST_COMMIT: r_state <= ST_NEXT;
                ST_NEXT: begin
                    if ({1'b0, r_j} + CW'(1) >= r_cnt) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + SW'(2);
                    end else r_j <= r_j + 1'b1;
                    r_state <= ST_PAIR;
                end
                ST_EMIT: r_state <= ST_EMIT2;
                ST_EMIT2: begin
                    if ({1'b0, r_i} + CW'(1) >= r_cnt) begin
                        r_cnt   <= '0;
                        r_busy  <= 1'b0;
                        r_state <= ST_LOAD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_EMIT;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx_i     = r_i;
        o_cmd.idx_j     = r_j;
        o_cmd.axis      = r_axis;
        o_cmd.load      = (r_state == ST_LOAD) && i_start &&
                          (r_cnt != CW'(ppm_pkg::MAX_PARTICLES));
        o_cmd.rd        = (r_state == ST_RD);
        o_cmd.dist_go   = (r_state == ST_CMP);
        o_cmd.mean_go   = (r_state == ST_MGO) && !i_sts.tot_zero;
        o_cmd.mean_save = (r_state == ST_MWAIT) && i_sts.div_done;
        o_cmd.commit    = (r_state == ST_COMMIT);
        o_cmd.emit_rd   = (r_state == ST_EMIT);
        o_cmd.emit      = (r_state == ST_EMIT);
        o_cmd.emit_last = (r_state == ST_EMIT) && ({1'b0, r_i} + CW'(1) >= r_cnt);
        o_cmd.clear     = (r_state == ST_EMIT2) && ({1'b0, r_i} + CW'(1) >= r_cnt);
    end

    assign o_busy   = r_busy;
    assign o_wr_idx = r_cnt[SW-1:0];
endmodule

/* verif/particle_pair_merge_core_tb.sv */
// ============================================================================
// particle_pair_merge_core_tb: self-checking bench of the particle merge core
// Loads particle sets through the input ports, predicts the merged slots in
// the bench and compares every emitted word field by field, in order.
// ============================================================================
module particle_pair_merge_core_tb;

    typedef struct packed {
        logic                                        valid_req;
        logic [ppm_pkg::ID_W-1:0]                    pid;
        logic [2:0][ppm_pkg::COORD_W-1:0]            pos;
        logic [2:0][ppm_pkg::COORD_W-1:0]            vel;
        logic [ppm_pkg::MASS_W-1:0]                  mass;
        logic [ppm_pkg::MRG_W-1:0]                   merges;
        logic                                        last_in;
    } t_particle;

    typedef struct packed {
        logic                                        alive;
        logic [ppm_pkg::ID_W-1:0]                    pid;
        logic [2:0][ppm_pkg::COORD_W-1:0]            pos;
        logic [2:0][ppm_pkg::COORD_W-1:0]            vel;
        logic [ppm_pkg::MASS_W-1:0]                  mass;
        logic [ppm_pkg::MRG_W-1:0]                   merges;
        logic                                        last_out;
    } t_slot_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [ppm_pkg::DIST_W-1:0] i_cfg_wdata = '0;
    t_particle drv = '0;
    logic o_strobe, o_alive, o_last_out;
    logic [ppm_pkg::ID_W-1:0] o_out_id;
    logic signed [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [31:0] o_out_vel_x, o_out_vel_y, o_out_vel_z;
    logic [ppm_pkg::MASS_W-1:0] o_out_mass;
    logic [ppm_pkg::MRG_W-1:0] o_out_merges;

    particle_pair_merge_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid_req(drv.valid_req), .i_particle_id(drv.pid),
        .i_pos_x(drv.pos[0]), .i_pos_y(drv.pos[1]), .i_pos_z(drv.pos[2]),
        .i_vel_x(drv.vel[0]), .i_vel_y(drv.vel[1]), .i_vel_z(drv.vel[2]),
        .i_mass(drv.mass), .i_merge_count(drv.merges), .i_last_in(drv.last_in),
        .o_strobe(o_strobe), .o_alive(o_alive), .o_out_id(o_out_id),
        .o_out_pos_x(o_out_pos_x), .o_out_pos_y(o_out_pos_y),
        .o_out_pos_z(o_out_pos_z), .o_out_vel_x(o_out_vel_x),
        .o_out_vel_y(o_out_vel_y), .o_out_vel_z(o_out_vel_z),
        .o_out_mass(o_out_mass), .o_out_merges(o_out_merges),
        .o_last_out(o_last_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bench copy of the block's state.
    logic [62:0]      dist_limit = '0;
    t_particle        slots[ppm_pkg::MAX_PARTICLES];
    logic             slot_live[ppm_pkg::MAX_PARTICLES];
    int unsigned      n_loaded = 0;

    t_particle  pending_words[$];
    t_slot_word expected_slots[$];
    int         mismatches = 0;
    int         errors = 0;
    longint     cycle_count = 0;
    int         gap_left = 0;
    bit         stim_done = 0;

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // Rounded mass-weighted mean of two coordinates, ties away from zero.
    function automatic logic [31:0] weighted_mean(logic [31:0] a, logic [63:0] ma,
                                                  logic [31:0] b, logic [63:0] mb,
                                                  logic [63:0] total);
        longint sa, sb;
        logic [63:0] pa, pb, mag, q, r;
        bit neg;
        longint res;
        sa = sx(a);
        sb = sx(b);
        pa = (sa < 0 ? -sa : sa) * ma;
        pb = (sb < 0 ? -sb : sb) * mb;
        if ((sa < 0) == (sb < 0)) begin
            mag = pa + pb; neg = sa < 0;
        end else if (pa >= pb) begin
            mag = pa - pb; neg = sa < 0;
        end else begin
            mag = pb - pa; neg = sb < 0;
        end
        q = mag / total;
        r = mag % total;
        if (r >= total - r) q++;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        res = neg ? -longint'(q) : longint'(q);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        return res[31:0];
    endfunction

    function automatic logic [63:0] separation_sq(int i, int j);
        logic [63:0] sum, m, s;
        longint diff;
        sum = 0;
        for (int d = 0; d < 3; d++) begin
            diff = sx(slots[i].pos[d]) - sx(slots[j].pos[d]);
            m = diff < 0 ? -diff : diff;
            s = m * m;
            if (sum > 64'hFFFF_FFFF_FFFF_FFFF - s) sum = '1;
            else sum = sum + s;
        end
        return sum;
    endfunction

    function automatic void combine_pair(int i, int j);
        logic [63:0] mi, mj, total;
        int keep, gone;
        logic [2:0][31:0] np, nv;
        mi = slots[i].mass;
        mj = slots[j].mass;
        total = mi + mj;
        keep = (mi >= mj) ? i : j;
        gone = (keep == i) ? j : i;
        if (total != 0) begin
            for (int d = 0; d < 3; d++) begin
                np[d] = weighted_mean(slots[i].pos[d], mi, slots[j].pos[d], mj, total);
                nv[d] = weighted_mean(slots[i].vel[d], mi, slots[j].vel[d], mj, total);
            end
            slots[keep].pos = np;
            slots[keep].vel = nv;
        end
        slots[keep].mass = total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : total[31:0];
        if (slots[keep].merges != 16'hFFFF) slots[keep].merges++;
        slot_live[gone] = 1'b0;
    endfunction

    function automatic void load_particle(t_particle p);
        t_slot_word w;
        if (n_loaded < ppm_pkg::MAX_PARTICLES) begin
            slots[n_loaded] = p;
            slot_live[n_loaded] = p.valid_req;
            n_loaded++;
        end
        if (!p.last_in) return;
        for (int i = 0; i + 1 < n_loaded; i++)
            for (int j = i + 1; j < n_loaded; j++)
                if (slot_live[i] && slot_live[j] && separation_sq(i, j) <= {1'b0, dist_limit})
                    combine_pair(i, j);
        for (int i = 0; i < n_loaded; i++) begin
            w = '0;
            if (slot_live[i]) begin
                w.alive = 1'b1;
                w.pid = slots[i].pid;
                w.pos = slots[i].pos;
                w.vel = slots[i].vel;
                w.mass = slots[i].mass;
                w.merges = slots[i].merges;
            end
            w.last_out = (i + 1 == n_loaded);
            expected_slots.push_back(w);
            slot_live[i] = 1'b0;
        end
        n_loaded = 0;
    endfunction

    // Driver: one word per accepted start, random gaps between words.
    // The word on the ports stays at the head of the queue until it is taken.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && !i_cfg_we) begin
            if (start && !busy) begin
                load_particle(drv);
                void'(pending_words.pop_front());
            end
            if (start && busy) begin
                // hold the current word
            end else if (pending_words.size() != 0 && gap_left == 0) begin
                start <= 1'b1;
                drv <= pending_words[0];
                gap_left <= $urandom_range(0, 5);
            end else begin
                start <= 1'b0;
                if (gap_left > 0 && !start) gap_left <= gap_left - 1;
                else if (start) gap_left <= gap_left;
            end
        end
    end

    // Monitor: every strobe carries one emitted slot.
    always @(posedge i_clk) begin
        t_slot_word got, want;
        if (i_rst_n && o_strobe) begin
            got = {o_alive, o_out_id, o_out_pos_z, o_out_pos_y, o_out_pos_x,
                   o_out_vel_z, o_out_vel_y, o_out_vel_x, o_out_mass, o_out_merges,
                   o_last_out};
            if (expected_slots.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected word %h", got);
            end else begin
                want = expected_slots.pop_front();
                if (got.alive !== want.alive || got.pid !== want.pid ||
                    got.pos !== want.pos || got.vel !== want.vel ||
                    got.mass !== want.mass || got.merges !== want.merges ||
                    got.last_out !== want.last_out) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("slot mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 3000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_particle random_particle(int mode);
        t_particle p;
        p.valid_req = ($urandom_range(0, 9) != 0);
        p.pid = ppm_pkg::ID_W'($urandom);
        p.mass = (mode == 0) ? $urandom : $urandom_range(0, 65536 * 8);
        if ($urandom_range(0, 9) == 0) p.mass = $urandom_range(0, 1) ? 0 : '1;
        p.merges = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        for (int d = 0; d < 3; d++) begin
            // Mostly clustered positions so that merges happen.
            p.pos[d] = (mode == 0) ? $urandom : 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            p.vel[d] = $urandom;
        end
        p.last_in = 1'b0;
        return p;
    endfunction

    task automatic send_set(int count, int mode);
        t_particle p;
        for (int k = 0; k < count; k++) begin
            p = random_particle(mode);
            p.last_in = (k == count - 1);
            pending_words.push_back(p);
        end
    endtask

    task automatic drain_and_write(logic [62:0] value);
        while (pending_words.size() != 0 || start || expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        dist_limit = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_particle p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero distance, only coincident points merge.
        p = '0;
        p.valid_req = 1; p.pid = '1; p.mass = 0;
        pending_words.push_back(p);
        p.pid = 1; p.last_in = 1;           // both masses zero
        pending_words.push_back(p);
        p = '0; p.last_in = 1;              // single empty slot
        pending_words.push_back(p);

        drain_and_write(63'h7FFF_FFFF_FFFF_FFFF);
        // Extremes: opposite corners, saturating mass and count, equal masses.
        p = '0; p.valid_req = 1; p.pid = 5;
        p.pos = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        p.vel = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        p.mass = '1; p.merges = 16'hFFFF;
        pending_words.push_back(p);
        p.pos = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        p.vel = {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        p.pid = 6;
        pending_words.push_back(p);
        p.valid_req = 0; p.pid = 7;
        pending_words.push_back(p);
        p.valid_req = 1; p.mass = 32'h1; p.pid = 8; p.merges = 0; p.last_in = 1;
        pending_words.push_back(p);
        // Overfull set: extra words dropped, last one still closes the set.
        for (int k = 0; k < ppm_pkg::MAX_PARTICLES + 3; k++) begin
            p = random_particle(1);
            p.last_in = (k == ppm_pkg::MAX_PARTICLES + 2);
            pending_words.push_back(p);
        end

        drain_and_write(63'd1 << 40);
        for (int s = 0; s < 8; s++) send_set($urandom_range(1, 6), 1);
        drain_and_write(63'd0);
        for (int s = 0; s < 6; s++) send_set($urandom_range(1, 8), $urandom_range(0, 1));
        drain_and_write(63'({$urandom, $urandom} >> 1));
        for (int s = 0; s < 6; s++) send_set($urandom_range(2, 8), $urandom_range(0, 1));
        drain_and_write(63'd1 << 36);
        for (int s = 0; s < 10; s++) send_set($urandom_range(1, 7), 1);

        while (pending_words.size() != 0 || start || expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
